[rtl/csrsm_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// csrsm_pkg: shared types and constants
// Sizes, status codes and sequencer states of the sparse matrix store.
// ----------------------------------------------------------------------------
package csrsm_pkg;
	localparam int MaxRows    = 256;
	localparam int MaxColumns = 256;
	localparam int MaxEntries = 4096;
	localparam int RowW  = $clog2(MaxRows);
	localparam int ColW  = $clog2(MaxColumns);
	localparam int PtrW  = $clog2(MaxEntries) + 1;
	localparam int AddrW = $clog2(MaxEntries);
	localparam int RsAW  = $clog2(MaxRows + 1);

	localparam logic [1:0] StatusOk    = 2'd0;
	localparam logic [1:0] StatusRange = 2'd1;
	localparam logic [1:0] StatusFull  = 2'd2;

	localparam logic OpRead  = 1'b0;
	localparam logic OpWrite = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE, ST_PTR0, ST_PTR1, ST_SCAN_RD, ST_SCAN_CHK, ST_DECIDE,
		ST_SHIFT_RD, ST_SHIFT_WR, ST_INSERT, ST_BUMP, ST_DONE
	} state_t;
endpackage
`default_nettype wire

[rtl/csr_sparse_matrix_store_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// csr_sparse_matrix_store_unit: compressed-sparse-row matrix store
// Looks up, overwrites and inserts 64-bit words kept in CSR form.
// ----------------------------------------------------------------------------
//  channel   signals                                   direction
//  in        valid ready operation row column value   sink
//  out       valid ready read_value status entry_total source
//  apb       psel penable pwrite paddr pwdata prdata   slave
//
// An item holds the block while it reads the two row pointers, compares
// the row's entries in column order and, for an insert, moves each later
// entry up, writes the new entry and bumps every row pointer above the row
// (256 minus the row of them). An index out of range goes straight to the
// result register. The single read port of the entry memory and the row
// pointer walk make the scan and the moves go one entry at a time.
// Reset clears row pointers (kept in flip-flops), the entry count and the
// control state; no clearing pass is needed. A stalled result holds in the
// output register and the block takes no item until it is taken.
// ----------------------------------------------------------------------------
module csr_sparse_matrix_store_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        operation,
	input  wire logic [7:0]  row,
	input  wire logic [7:0]  column,
	input  wire logic [63:0] value,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [63:0]      read_value,
	output logic [1:0]       status,
	output logic [12:0]      entry_total,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	localparam int PtrW  = csrsm_pkg::PtrW;
	localparam int AddrW = csrsm_pkg::AddrW;

	logic [8:0] row_count_q, col_count_q;
	logic [PtrW-1:0] row_start_q [csrsm_pkg::MaxRows+1];
	logic [PtrW-1:0] entry_count_q;

	csrsm_pkg::state_t state_q, state_d;

	logic              op_q;
	logic [7:0]        row_q, col_q;
	logic [63:0]       val_q;
	logic [PtrW-1:0]   start_q, end_q, pos_q, k_q;
	logic [8:0]        bump_q;
	logic              found_q;
	logic [63:0]       rd_q;
	logic [1:0]        stat_q;

	logic              ram_we;
	logic [AddrW-1:0]  ram_waddr, ram_raddr;
	logic [7:0]        ram_wcol, ram_rcol;
	logic [63:0]       ram_wval, ram_rval;

	csrsm_entry_ram u_ram (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wcol(ram_wcol), .wval(ram_wval),
		.raddr(ram_raddr), .rcol(ram_rcol), .rval(ram_rval)
	);

	// APB: two 9-bit registers; writes are for the user to make only while idle, the block does not enforce it.
	assign pready = 1'b1;
	logic cfg_we;
	assign cfg_we = psel && penable && pwrite;
	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			1'b0: prdata = {23'd0, row_count_q};
			1'b1: prdata = {23'd0, col_count_q};
			default: prdata = '0;
		endcase
		if (paddr[1:0] != 2'd0) prdata = '0;
	end

	// Clamp a pointer to the entry count, as the lookup expects.
	function automatic logic [PtrW-1:0] safe(input logic [PtrW-1:0] p,
		input logic [PtrW-1:0] n);
		return (p < n) ? p : n;
	endfunction

	logic range_bad;
	assign range_bad = ({1'b0, row} >= row_count_q) || ({1'b0, column} >= col_count_q);
	logic nonzero;
	assign nonzero = (val_q[62:0] != 63'd0);

	assign in_ready  = (state_q == csrsm_pkg::ST_IDLE);
	assign out_valid = (state_q == csrsm_pkg::ST_DONE);
	assign read_value  = rd_q;
	assign status      = stat_q;
	assign entry_total = entry_count_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			csrsm_pkg::ST_IDLE:
				if (in_valid) state_d = range_bad ? csrsm_pkg::ST_DONE : csrsm_pkg::ST_PTR0;
			csrsm_pkg::ST_PTR0: state_d = csrsm_pkg::ST_PTR1;
			csrsm_pkg::ST_PTR1: state_d = csrsm_pkg::ST_SCAN_RD;
			csrsm_pkg::ST_SCAN_RD:
				state_d = (pos_q < end_q) ? csrsm_pkg::ST_SCAN_CHK : csrsm_pkg::ST_DECIDE;
			csrsm_pkg::ST_SCAN_CHK:
				state_d = (ram_rcol >= col_q) ? csrsm_pkg::ST_DECIDE : csrsm_pkg::ST_SCAN_RD;
			csrsm_pkg::ST_DECIDE: begin
				priority if (op_q == csrsm_pkg::OpRead || found_q || !nonzero)
					state_d = csrsm_pkg::ST_DONE;
				else if (entry_count_q >= PtrW'(csrsm_pkg::MaxEntries))
					state_d = csrsm_pkg::ST_DONE;
				else if (entry_count_q > pos_q) state_d = csrsm_pkg::ST_SHIFT_RD;
				else state_d = csrsm_pkg::ST_INSERT;
			end
			csrsm_pkg::ST_SHIFT_RD: state_d = csrsm_pkg::ST_SHIFT_WR;
			csrsm_pkg::ST_SHIFT_WR:
				state_d = (k_q - 1'b1 > pos_q) ? csrsm_pkg::ST_SHIFT_RD : csrsm_pkg::ST_INSERT;
			csrsm_pkg::ST_INSERT: state_d = csrsm_pkg::ST_BUMP;
			csrsm_pkg::ST_BUMP:
				if (bump_q == 9'(csrsm_pkg::MaxRows - 1)) state_d = csrsm_pkg::ST_DONE;
			csrsm_pkg::ST_DONE: if (out_ready) state_d = csrsm_pkg::ST_IDLE;
			default: state_d = csrsm_pkg::ST_IDLE;
		endcase
	end

	// Memory port control.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = AddrW'(pos_q);
		ram_wcol  = col_q;
		ram_wval  = val_q;
		ram_raddr = AddrW'(pos_q);
		unique case (state_q)
			csrsm_pkg::ST_SHIFT_RD: ram_raddr = AddrW'(k_q - 1'b1);
			csrsm_pkg::ST_SHIFT_WR: begin
				ram_we = 1'b1; ram_waddr = AddrW'(k_q);
				ram_wcol = ram_rcol; ram_wval = ram_rval;
			end
			csrsm_pkg::ST_DECIDE: begin
				ram_we = (op_q == csrsm_pkg::OpWrite) && found_q;
			end
			csrsm_pkg::ST_INSERT: ram_we = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			csrsm_pkg::ST_IDLE: begin
				op_q <= operation; row_q <= row; col_q <= column; val_q <= value;
				found_q <= 1'b0; rd_q <= '0;
				stat_q <= range_bad ? csrsm_pkg::StatusRange : csrsm_pkg::StatusOk;
			end
			csrsm_pkg::ST_PTR0: start_q <= safe(row_start_q[{1'b0, row_q}], entry_count_q);
			csrsm_pkg::ST_PTR1: begin
				end_q <= (safe(row_start_q[{1'b0, row_q} + 9'd1], entry_count_q) < start_q)
					? start_q : safe(row_start_q[{1'b0, row_q} + 9'd1], entry_count_q);
				pos_q <= start_q;
			end
			csrsm_pkg::ST_SCAN_CHK: begin
				if (ram_rcol == col_q) found_q <= 1'b1;
				if (ram_rcol < col_q) pos_q <= pos_q + 1'b1;
			end
			csrsm_pkg::ST_DECIDE: begin
				k_q <= entry_count_q;
				bump_q <= {1'b0, row_q};
				if (op_q == csrsm_pkg::OpRead && found_q) rd_q <= ram_rval;
				if (op_q == csrsm_pkg::OpWrite && !found_q && nonzero &&
					entry_count_q >= PtrW'(csrsm_pkg::MaxEntries))
					stat_q <= csrsm_pkg::StatusFull;
			end
			csrsm_pkg::ST_SHIFT_WR: k_q <= k_q - 1'b1;
			csrsm_pkg::ST_BUMP: bump_q <= bump_q + 1'b1;
			default: ;
		endcase
	end

	// Control registers, row pointers and entry count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= csrsm_pkg::ST_IDLE;
			row_count_q <= 9'd256;
			col_count_q <= 9'd256;
			entry_count_q <= '0;
			for (int i = 0; i <= csrsm_pkg::MaxRows; i++) row_start_q[i] <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we && paddr == 3'd0) row_count_q <= pwdata[8:0];
			if (cfg_we && paddr == 3'd4) col_count_q <= pwdata[8:0];
			if (state_q == csrsm_pkg::ST_INSERT) entry_count_q <= entry_count_q + 1'b1;
			if (state_q == csrsm_pkg::ST_BUMP)
				row_start_q[bump_q + 9'd1] <= row_start_q[bump_q + 9'd1] + 1'b1;
		end
	end
endmodule
`default_nettype wire

[rtl/csrsm_entry_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// csrsm_entry_ram: entry memory
// One write port and one registered read port holding column and value.
// ----------------------------------------------------------------------------
module csrsm_entry_ram (
	input  wire logic                           clk,
	input  wire logic                           we,
	input  wire logic [csrsm_pkg::AddrW-1:0]    waddr,
	input  wire logic [csrsm_pkg::ColW-1:0]     wcol,
	input  wire logic [63:0]                    wval,
	input  wire logic [csrsm_pkg::AddrW-1:0]    raddr,
	output logic      [csrsm_pkg::ColW-1:0]     rcol,
	output logic      [63:0]                    rval
);
	logic [csrsm_pkg::ColW-1:0] col_mem [csrsm_pkg::MaxEntries];
	logic [63:0]                val_mem [csrsm_pkg::MaxEntries];

	always_ff @(posedge clk) begin
		if (we) begin
			col_mem[waddr] <= wcol;
			val_mem[waddr] <= wval;
		end
		rcol <= col_mem[raddr];
		rval <= val_mem[raddr];
	end
endmodule
`default_nettype wire

[sim/csr_sparse_matrix_store_unit_tb.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// csr_sparse_matrix_store_unit_tb: self-checking bench for the CSR store
// Drives lookups, overwrites and inserts through the valid/ready input
// channel and programs the row and column limits over the APB port. A
// behavioral copy of the CSR structure predicts each result word the table
// does not give; every word is compared field by field as it leaves the block.
// ----------------------------------------------------------------------------
module csr_sparse_matrix_store_unit_tb;
	localparam int RegRowCount    = 0;
	localparam int RegColumnCount = 1;
	localparam int RandomItems    = 960;
	localparam int DrainCycles    = 64;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct packed {
		logic [63:0] rd;
		logic [1:0]  st;
		logic [12:0] tot;
	} result_t;

	// One line of the directed table. A register write reuses row as the
	// register index and val as the data.
	typedef struct packed {
		row_kind_t   kind;
		logic        op;
		logic [7:0]  row;
		logic [7:0]  col;
		logic [63:0] val;
		logic        known;
		result_t     res;
	} stim_row_t;

	localparam logic [63:0] NegZero = 64'h8000_0000_0000_0000;
	localparam logic [63:0] AllOnes = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] PosInf  = 64'h7FF0_0000_0000_0000;
	localparam result_t     NoRes   = '{rd: 64'd0, st: csrsm_pkg::StatusOk, tot: 13'd0};

	localparam int DirRows = 24;
	localparam stim_row_t DirTable [DirRows] = '{
		// empty store: reads at both corners miss, zero writes do nothing
		'{ROW_ITEM, csrsm_pkg::OpRead,  8'd0,   8'd0,   64'd0,   1'b1,
			'{64'd0, csrsm_pkg::StatusOk, 13'd0}},
		'{ROW_ITEM, csrsm_pkg::OpRead,  8'd255, 8'd255, 64'd0,   1'b1,
			'{64'd0, csrsm_pkg::StatusOk, 13'd0}},
		'{ROW_ITEM, csrsm_pkg::OpWrite, 8'd3,   8'd3,   64'd0,   1'b1,
			'{64'd0, csrsm_pkg::StatusOk, 13'd0}},
		'{ROW_ITEM, csrsm_pkg::OpWrite, 8'd3,   8'd3,   NegZero, 1'b1,
			'{64'd0, csrsm_pkg::StatusOk, 13'd0}},
		// inserts at first and last slot, then read back
		'{ROW_ITEM, csrsm_pkg::OpWrite, 8'd0,   8'd0,   AllOnes, 1'b1,
			'{64'd0, csrsm_pkg::StatusOk, 13'd1}},
		'{ROW_ITEM, csrsm_pkg::OpWrite, 8'd255, 8'd255, PosInf,  1'b1,
			'{64'd0, csrsm_pkg::StatusOk, 13'd2}},
		'{ROW_ITEM, csrsm_pkg::OpRead,  8'd0,   8'd0,   64'd0,   1'b1,
			'{AllOnes, csrsm_pkg::StatusOk, 13'd2}},
		'{ROW_ITEM, csrsm_pkg::OpRead,  8'd255, 8'd255, 64'd0,   1'b1,
			'{PosInf, csrsm_pkg::StatusOk, 13'd2}},
		// sorted insert inside a row and into the next row
		'{ROW_ITEM, csrsm_pkg::OpWrite, 8'd0,   8'd5,   64'd1,   1'b0, NoRes},
		'{ROW_ITEM, csrsm_pkg::OpWrite, 8'd0,   8'd2,   64'd2,   1'b0, NoRes},
		'{ROW_ITEM, csrsm_pkg::OpWrite, 8'd1,   8'd0,   64'd3,   1'b0, NoRes},
		'{ROW_ITEM, csrsm_pkg::OpRead,  8'd0,   8'd2,   64'd0,   1'b0, NoRes},
		// overwrite with zero keeps the entry present
		'{ROW_ITEM, csrsm_pkg::OpWrite, 8'd0,   8'd0,   64'd0,   1'b1,
			'{64'd0, csrsm_pkg::StatusOk, 13'd5}},
		'{ROW_ITEM, csrsm_pkg::OpRead,  8'd0,   8'd0,   64'd0,   1'b1,
			'{64'd0, csrsm_pkg::StatusOk, 13'd5}},
		'{ROW_ITEM, csrsm_pkg::OpWrite, 8'd1,   8'd0,   NegZero, 1'b0, NoRes},
		'{ROW_ITEM, csrsm_pkg::OpRead,  8'd0,   8'd3,   64'd0,   1'b0, NoRes},
		// index out of range against shrunk limits, zero limit included
		'{ROW_CFG,  csrsm_pkg::OpWrite, 8'(RegRowCount), 8'd0, 64'd1, 1'b0, NoRes},
		'{ROW_ITEM, csrsm_pkg::OpRead,  8'd1,   8'd0,   64'd0,   1'b1,
			'{64'd0, csrsm_pkg::StatusRange, 13'd5}},
		'{ROW_ITEM, csrsm_pkg::OpRead,  8'd0,   8'd0,   64'd0,   1'b0, NoRes},
		'{ROW_CFG,  csrsm_pkg::OpWrite, 8'(RegColumnCount), 8'd0, 64'd0, 1'b0, NoRes},
		'{ROW_ITEM, csrsm_pkg::OpRead,  8'd0,   8'd0,   64'd0,   1'b1,
			'{64'd0, csrsm_pkg::StatusRange, 13'd5}},
		// limits above the array size clamp to it
		'{ROW_CFG,  csrsm_pkg::OpWrite, 8'(RegRowCount), 8'd0, 64'd511, 1'b0, NoRes},
		'{ROW_CFG,  csrsm_pkg::OpWrite, 8'(RegColumnCount), 8'd0, 64'd511, 1'b0, NoRes},
		'{ROW_ITEM, csrsm_pkg::OpWrite, 8'd255, 8'd254, 64'h8000_0000_0000_0001, 1'b0, NoRes}
	};

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        operation;
	logic [7:0]  row;
	logic [7:0]  column;
	logic [63:0] value;
	logic        out_valid;
	logic        out_ready;
	logic [63:0] read_value;
	logic [1:0]  status;
	logic [12:0] entry_total;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	csr_sparse_matrix_store_unit uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.operation(operation), .row(row), .column(column), .value(value),
		.out_valid(out_valid), .out_ready(out_ready),
		.read_value(read_value), .status(status), .entry_total(entry_total),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Shadow copy of the CSR structure and the two limit registers
	logic [12:0] shadow_row_start [csrsm_pkg::MaxRows+1];
	logic [7:0]  shadow_col [csrsm_pkg::MaxEntries];
	logic [63:0] shadow_word [csrsm_pkg::MaxEntries];
	int          shadow_count;
	logic [8:0]  shadow_rows;
	logic [8:0]  shadow_cols;

	result_t pending_results[$];
	int      errors;
	int      words_checked;
	int      full_seen;
	int      range_seen;
	int      send_idle_pct;
	int      recv_stall_pct;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Compute the result of one word and update the shadow structure
	function automatic result_t csr_apply(logic op, logic [7:0] r, logic [7:0] c,
			logic [63:0] v);
		result_t res;
		int      lim_r;
		int      lim_c;
		int      first;
		int      last;
		int      pos;
		bit      hit;
		res = '{rd: 64'd0, st: csrsm_pkg::StatusOk, tot: 13'd0};
		lim_r = (shadow_rows < csrsm_pkg::MaxRows) ? shadow_rows : csrsm_pkg::MaxRows;
		lim_c = (shadow_cols < csrsm_pkg::MaxColumns) ? shadow_cols : csrsm_pkg::MaxColumns;
		if (r >= lim_r || c >= lim_c) begin
			res.st = csrsm_pkg::StatusRange;
		end else begin
			first = (shadow_row_start[r] < shadow_count) ? shadow_row_start[r] : shadow_count;
			last = (shadow_row_start[r+1] < shadow_count) ? shadow_row_start[r+1]
				: shadow_count;
			if (last < first)
				last = first;
			pos = first;
			hit = 1'b0;
			while (pos < last && !hit && shadow_col[pos] <= c) begin
				if (shadow_col[pos] == c)
					hit = 1'b1;
				else
					pos++;
			end
			if (op == csrsm_pkg::OpRead) begin
				if (hit)
					res.rd = shadow_word[pos];
			end else if (hit) begin
				shadow_word[pos] = v;
			end else if (v[62:0] != 63'd0) begin
				if (shadow_count >= csrsm_pkg::MaxEntries) begin
					res.st = csrsm_pkg::StatusFull;
				end else begin
					for (int k = shadow_count; k > pos; k--) begin
						shadow_col[k] = shadow_col[k-1];
						shadow_word[k] = shadow_word[k-1];
					end
					shadow_col[pos] = c;
					shadow_word[pos] = v;
					shadow_count++;
					for (int l = r; l < csrsm_pkg::MaxRows; l++)
						shadow_row_start[l+1] = shadow_row_start[l+1] + 13'd1;
				end
			end
		end
		res.tot = 13'(shadow_count);
		return res;
	endfunction

	// Present one word, wait for it to be taken and queue its result
	task automatic send_word(logic op, logic [7:0] r, logic [7:0] c, logic [63:0] v,
			logic known, result_t typed);
		result_t res;
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(negedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		row <= r;
		column <= c;
		value <= v;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		res = csr_apply(op, r, c, v);
		pending_results.push_back(known ? typed : res);
		@(negedge clk);
	endtask

	// Drop valid and hold until every result has left the block
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Register write in setup and access phases; call only while the block is idle
	task automatic write_reg(int idx, logic [8:0] data);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= 3'(4 * idx);
		pwdata <= 32'(data);
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == RegRowCount)
			shadow_rows = data;
		else
			shadow_cols = data;
	endtask

	task automatic set_limits(logic [8:0] rows_lim, logic [8:0] cols_lim);
		wait_idle();
		write_reg(RegRowCount, rows_lim);
		write_reg(RegColumnCount, cols_lim);
	endtask

	// Pick idle rates; every 40 words the pattern moves on
	task automatic pick_idling(int idx);
		case ((idx / 40) % 4)
			0: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			1: begin
				send_idle_pct = 49;
				recv_stall_pct = 0;
			end
			2: begin
				send_idle_pct = 0;
				recv_stall_pct = 49;
			end
			default: begin
				send_idle_pct = 6;
				recv_stall_pct = 6;
			end
		endcase
	endtask

	// Receiver backpressure, changed at the falling edge
	always @(negedge clk) begin
		if (arst_n)
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Compare each taken result word with the oldest prediction
	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result word rd=%h st=%0d tot=%0d",
					$time, read_value, status, entry_total);
			end else begin
				want = pending_results.pop_front();
				words_checked++;
				if (status == csrsm_pkg::StatusFull)
					full_seen++;
				if (status == csrsm_pkg::StatusRange)
					range_seen++;
				if (read_value !== want.rd) begin
					errors++;
					$display("%0t: read_value expected %h actual %h",
						$time, want.rd, read_value);
				end
				if (status !== want.st) begin
					errors++;
					$display("%0t: status expected %0d actual %0d",
						$time, want.st, status);
				end
				if (entry_total !== want.tot) begin
					errors++;
					$display("%0t: entry_total expected %0d actual %0d",
						$time, want.tot, entry_total);
				end
			end
		end
	end

	// Hard stop well past the slowest legal run
	initial begin
		#400_000_000;
		$display("csr_sparse_matrix_store_unit regression: fail");
		$finish;
	end

	initial begin
		logic        op;
		logic [7:0]  r;
		logic [7:0]  c;
		logic [63:0] v;
		int          pick;
		logic [8:0]  lim_rows [6];
		logic [8:0]  lim_cols [6];

		errors = 0;
		words_checked = 0;
		full_seen = 0;
		range_seen = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = csrsm_pkg::OpRead;
		row = 8'd0;
		column = 8'd0;
		value = 64'd0;
		out_ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = 3'd0;
		pwdata = 32'd0;
		shadow_count = 0;
		shadow_rows = 9'd256;
		shadow_cols = 9'd256;
		foreach (shadow_row_start[i])
			shadow_row_start[i] = 13'd0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed table; register rows wait for the block to drain
		foreach (DirTable[i]) begin
			if (DirTable[i].kind == ROW_CFG) begin
				wait_idle();
				write_reg(int'(DirTable[i].row), DirTable[i].val[8:0]);
			end else begin
				send_word(DirTable[i].op, DirTable[i].row, DirTable[i].col,
					DirTable[i].val, DirTable[i].known, DirTable[i].res);
			end
		end

		// Random part: six limit settings, extremes among them. Writes stay
		// mostly in the lower rows and columns so rows grow long.
		lim_rows = '{9'd256, 9'd1, 9'd128, 9'd511, 9'd0, 9'd256};
		lim_cols = '{9'd256, 9'd256, 9'd16, 9'd511, 9'd256, 9'd1};
		lim_rows[4] = 9'($urandom_range(1, 300));
		lim_cols[4] = 9'($urandom_range(1, 300));
		for (int b = 0; b < 6; b++) begin
			set_limits(lim_rows[b], lim_cols[b]);
			for (int i = 0; i < RandomItems / 6; i++) begin
				pick_idling(i);
				op = 1'($urandom_range(1));
				pick = $urandom_range(99);
				r = (pick < 50) ? 8'($urandom_range(7))
					: (pick < 85) ? 8'($urandom_range(127)) : 8'($urandom);
				c = ($urandom_range(99) < 60) ? 8'($urandom_range(15)) : 8'($urandom);
				pick = $urandom_range(99);
				v = (pick < 10) ? 64'd0 : (pick < 15) ? NegZero : {$urandom, $urandom};
				send_word(op, r, c, v, 1'b0, NoRes);
			end
		end

		wait_idle();
		repeat (DrainCycles) @(negedge clk);
		$display("covered %0d result words, %0d out of range, %0d refused as full",
			words_checked, range_seen, full_seen);
		$display("limits swept through zero, one, array size and above; store holds %0d",
			shadow_count);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("csr_sparse_matrix_store_unit regression: pass");
		end else begin
			$display("csr_sparse_matrix_store_unit regression: fail");
		end
		$finish;
	end
endmodule
`default_nettype wire
